>>> rtl/core/tfss_pkg.sv
package tfss_pkg;

    // Field width of every temperature on the ports and in the frame store.
    localparam int TEMP_BITS = 16;

    localparam logic signed [31:0] TEMP_HI = 32'sd32767;
    localparam logic signed [31:0] TEMP_LO = -32'sd32768;

    // Valid raw pixel window in 1/16 C (-100 C .. 1000 C, bounds included).
    localparam logic signed [15:0] PIX_LOW_LIMIT  = -16'sd1600;
    localparam logic signed [15:0] PIX_HIGH_LIMIT = 16'sd16000;

    // 18*C + 5 is lifted by 10*65536 so the divide by ten works on unsigned values.
    localparam logic signed [21:0] CONV_OFFSET = 22'sd655365;
    // Removes the lift again and adds 32 F (512 sixteenths).
    localparam logic signed [31:0] CONV_BIAS = 32'sd65024;

    // 13*old + 7*new + 10 is lifted by 20*65536 before the divide by twenty.
    localparam logic signed [21:0] AVG_OFFSET = 22'sd1310730;
    localparam logic signed [31:0] AVG_BIAS   = 32'sd65536;

    // floor(2^23 / 5): reciprocal for the divide-by-five unit.
    localparam logic [20:0] DIV5_RECIP = 21'd1677721;
    localparam int          DIV5_SHIFT = 23;

    localparam logic [8:0] ALPHA_ONE   = 9'd256;
    localparam logic [8:0] ALPHA_RESET = 9'd64;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_ALPHA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTER_COL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTER_ROW  = 2'd2;

    typedef struct packed {
        logic signed [15:0] pixel_temp_c;
        logic               pixel_not_number;
        logic signed [15:0] ambient_temp_c;
    } pixel_in_t;

    typedef struct packed {
        logic signed [15:0] smoothed_f;
        logic               frame_done;
        logic signed [15:0] frame_min_f;
        logic signed [15:0] frame_max_f;
        logic        [4:0]  hotspot_col;
        logic        [4:0]  hotspot_row;
        logic signed [15:0] center_f;
        logic signed [15:0] pointer_f;
        logic signed [15:0] pointer_display_f;
        logic signed [15:0] ambient_f;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONV_MUL,
        ST_CONV_FIX,
        ST_BLEND_MUL,
        ST_BLEND_SUM,
        ST_RD_CENTER,
        ST_RD_POINTER,
        ST_CAP_POINTER,
        ST_AMB_FIX,
        ST_AVG_MUL,
        ST_AVG_FIX,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        DIV_PIXEL,
        DIV_AMB,
        DIV_AVG
    } div_sel_t;

    typedef struct packed {
        logic     accept;
        logic     cap_old;
        logic     div_load;
        logic     div_fix;
        div_sel_t div_sel;
        logic     blend_mul;
        logic     blend_write;
        logic     rd_center;
        logic     rd_pointer;
        logic     cap_center;
        logic     cap_pointer;
        logic     avg_sum;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic last_pixel;
    } status_t;

    function automatic logic signed [15:0] sat_temp(input logic signed [31:0] v);
        logic signed [15:0] r;
        if (v > TEMP_HI)
            r = 16'(TEMP_HI);
        else if (v < TEMP_LO)
            r = 16'(TEMP_LO);
        else
            r = 16'(v);
        return r;
    endfunction

endpackage

>>> rtl/core/tfss_ram.sv
module tfss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/tfss_ctrl.sv
module tfss_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pixel_valid,
    output logic              pixel_ready,
    output logic              result_valid,
    input  logic              result_ready,
    input  tfss_pkg::status_t status,
    output tfss_pkg::cmd_t    cmd
);

    tfss_pkg::state_t state_reg, state_next;
    logic             result_valid_reg, result_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tfss_pkg::ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        pixel_ready = 1'b0;
        cmd         = '0;
        cmd.div_sel = tfss_pkg::DIV_PIXEL;
        case (state_reg)
            tfss_pkg::ST_IDLE:
            begin
                pixel_ready = 1'b1;
                if (pixel_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = tfss_pkg::ST_CONV_MUL;
                end
            end
            tfss_pkg::ST_CONV_MUL:
            begin
                cmd.cap_old  = 1'b1;
                cmd.div_load = 1'b1;
                cmd.div_sel  = tfss_pkg::DIV_PIXEL;
                state_next   = tfss_pkg::ST_CONV_FIX;
            end
            tfss_pkg::ST_CONV_FIX:
            begin
                cmd.div_fix = 1'b1;
                cmd.div_sel = tfss_pkg::DIV_PIXEL;
                state_next  = tfss_pkg::ST_BLEND_MUL;
            end
            tfss_pkg::ST_BLEND_MUL:
            begin
                cmd.blend_mul = 1'b1;
                state_next    = tfss_pkg::ST_BLEND_SUM;
            end
            tfss_pkg::ST_BLEND_SUM:
            begin
                cmd.blend_write = 1'b1;
                state_next = status.last_pixel ? tfss_pkg::ST_RD_CENTER : tfss_pkg::ST_EMIT;
            end
            tfss_pkg::ST_RD_CENTER:
            begin
                cmd.rd_center = 1'b1;
                state_next    = tfss_pkg::ST_RD_POINTER;
            end
            tfss_pkg::ST_RD_POINTER:
            begin
                cmd.rd_pointer = 1'b1;
                cmd.cap_center = 1'b1;
                state_next     = tfss_pkg::ST_CAP_POINTER;
            end
            tfss_pkg::ST_CAP_POINTER:
            begin
                cmd.cap_pointer = 1'b1;
                cmd.div_load    = 1'b1;
                cmd.div_sel     = tfss_pkg::DIV_AMB;
                state_next      = tfss_pkg::ST_AMB_FIX;
            end
            tfss_pkg::ST_AMB_FIX:
            begin
                cmd.div_fix = 1'b1;
                cmd.div_sel = tfss_pkg::DIV_AMB;
                cmd.avg_sum = 1'b1;
                state_next  = tfss_pkg::ST_AVG_MUL;
            end
            tfss_pkg::ST_AVG_MUL:
            begin
                cmd.div_load = 1'b1;
                cmd.div_sel  = tfss_pkg::DIV_AVG;
                state_next   = tfss_pkg::ST_AVG_FIX;
            end
            tfss_pkg::ST_AVG_FIX:
            begin
                cmd.div_fix = 1'b1;
                cmd.div_sel = tfss_pkg::DIV_AVG;
                state_next  = tfss_pkg::ST_EMIT;
            end
            tfss_pkg::ST_EMIT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = tfss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tfss_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    assign result_valid = result_valid_reg;

endmodule

>>> rtl/core/tfss_datapath.sv
module tfss_datapath #(
    parameter int FRAME_WIDTH  = 32,
    parameter int FRAME_HEIGHT = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tfss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tfss_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  tfss_pkg::pixel_in_t                 pixel,
    input  tfss_pkg::cmd_t                      cmd,
    output tfss_pkg::status_t                   status,
    output tfss_pkg::result_t                   result
);

    localparam int NPIX       = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W     = $clog2(NPIX);
    localparam int COL_W      = $clog2(FRAME_WIDTH);
    localparam int ROW_W      = $clog2(FRAME_HEIGHT);
    localparam int CENTER_IDX = (FRAME_HEIGHT / 2) * FRAME_WIDTH + FRAME_WIDTH / 2;
    localparam logic [ADDR_W-1:0] LAST_IDX   = ADDR_W'(NPIX - 1);
    localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(FRAME_WIDTH - 1);
    localparam logic [ADDR_W-1:0] CENTER_ADR = ADDR_W'(CENTER_IDX);

    // Configuration registers.
    logic [8:0] alpha_reg;
    logic [4:0] pcol_reg;
    logic [4:0] prow_reg;

    // Raster position.
    logic [ADDR_W-1:0] idx_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;

    // Per-pixel working registers.
    logic signed [15:0] temp_reg;
    logic signed [15:0] amb_reg;
    logic signed [15:0] old_reg;
    logic signed [15:0] f_reg;
    logic signed [26:0] prod_reg;
    logic signed [15:0] s_reg;
    logic               done_reg;

    // Divide-by-five unit.
    logic [19:0] z_reg;
    logic [17:0] est_reg;

    // Frame statistics and summary.
    logic               frame_seen_reg;
    logic signed [15:0] min_reg;
    logic signed [15:0] max_reg;
    logic [COL_W-1:0]   hot_col_reg;
    logic [ROW_W-1:0]   hot_row_reg;
    logic signed [15:0] center_reg;
    logic signed [15:0] pointer_reg;
    logic signed [15:0] pavg_reg;
    logic               pavg_seen_reg;
    logic signed [15:0] ambf_reg;
    logic signed [21:0] avg_y_reg;

    tfss_pkg::result_t result_reg;
    tfss_pkg::result_t result_next;

    logic [ADDR_W-1:0]            ptr_addr;
    logic [ADDR_W-1:0]            raddr;
    logic                         re;
    logic [tfss_pkg::TEMP_BITS-1:0] rdata;
    logic [8:0]                   a_eff;
    logic                         bad_pixel;
    logic signed [15:0]           conv_src;
    logic signed [21:0]           conv_x;
    logic [19:0]                  z_next;
    logic [40:0]                  div_prod;
    logic [20:0]                  div_rem;
    logic [17:0]                  div_q;
    logic signed [31:0]           div_bias;
    logic signed [15:0]           div_res;
    logic signed [16:0]           blend_diff;
    logic signed [26:0]           blend_sum;
    logic signed [15:0]           s_blend;
    logic signed [15:0]           s_next;
    logic                         first_pixel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= tfss_pkg::ALPHA_RESET;
            pcol_reg  <= '0;
            prow_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tfss_pkg::CFG_SMOOTH_ALPHA:
                begin
                    alpha_reg <= cfg_wdata;
                end
                tfss_pkg::CFG_POINTER_COL:
                begin
                    pcol_reg <= (32'(cfg_wdata[4:0]) > 32'(FRAME_WIDTH - 1)) ?
                                5'(FRAME_WIDTH - 1) : cfg_wdata[4:0];
                end
                tfss_pkg::CFG_POINTER_ROW:
                begin
                    prow_reg <= (32'(cfg_wdata[4:0]) > 32'(FRAME_HEIGHT - 1)) ?
                                5'(FRAME_HEIGHT - 1) : cfg_wdata[4:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign a_eff     = (alpha_reg > tfss_pkg::ALPHA_ONE) ? tfss_pkg::ALPHA_ONE : alpha_reg;
    assign ptr_addr  = ADDR_W'(32'(prow_reg) * 32'(FRAME_WIDTH) + 32'(pcol_reg));
    assign bad_pixel = pixel.pixel_not_number ||
                       (pixel.pixel_temp_c < tfss_pkg::PIX_LOW_LIMIT) ||
                       (pixel.pixel_temp_c > tfss_pkg::PIX_HIGH_LIMIT);

    // Frame store: one read port shared by the pixel fetch and the summary probes.
    always_comb
    begin
        re    = cmd.accept || cmd.rd_center || cmd.rd_pointer;
        raddr = idx_reg;
        if (cmd.rd_center)
            raddr = CENTER_ADR;
        else if (cmd.rd_pointer)
            raddr = ptr_addr;
    end

    tfss_ram #(
        .WIDTH (tfss_pkg::TEMP_BITS),
        .DEPTH (NPIX)
    ) u_frame_ram (
        .clk   (clk),
        .we    (cmd.blend_write),
        .waddr (idx_reg),
        .wdata (s_next),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Divide by five through a reciprocal multiply, then one correction step.
    always_comb
    begin
        conv_src = (cmd.div_sel == tfss_pkg::DIV_AMB) ? amb_reg : temp_reg;
        conv_x   = (22'(conv_src) <<< 4) + (22'(conv_src) <<< 1) + tfss_pkg::CONV_OFFSET;
        if (cmd.div_sel == tfss_pkg::DIV_AVG)
            z_next = {1'b0, avg_y_reg[20:2]};
        else
            z_next = conv_x[20:1];
        div_prod = 41'(z_next) * 41'(tfss_pkg::DIV5_RECIP);
        div_rem  = 21'(z_reg) - (21'(est_reg) << 2) - 21'(est_reg);
        div_q    = est_reg + {17'b0, (div_rem >= 21'd5)};
        div_bias = (cmd.div_sel == tfss_pkg::DIV_AVG) ? tfss_pkg::AVG_BIAS : tfss_pkg::CONV_BIAS;
        div_res  = tfss_pkg::sat_temp($signed({14'b0, div_q}) - div_bias);
    end

    // Blend as old + (new - old) * alpha, rounded to nearest (halves up) after the 1/256 scale.
    always_comb
    begin
        blend_diff = 17'(f_reg) - 17'(old_reg);
        blend_sum  = (27'(old_reg) <<< 8) + prod_reg + 27'sd128;
        s_blend    = tfss_pkg::sat_temp(32'(blend_sum >>> 8));
        s_next     = frame_seen_reg ? s_blend : f_reg;
    end

    // Summary fields are zero except on the last pixel of a frame.
    always_comb
    begin
        result_next            = '0;
        result_next.smoothed_f = s_reg;
        if (done_reg)
        begin
            result_next.frame_done        = 1'b1;
            result_next.frame_min_f       = min_reg;
            result_next.frame_max_f       = max_reg;
            result_next.hotspot_col       = 5'(hot_col_reg);
            result_next.hotspot_row       = 5'(hot_row_reg);
            result_next.center_f          = center_reg;
            result_next.pointer_f         = pointer_reg;
            result_next.pointer_display_f = pavg_reg;
            result_next.ambient_f         = ambf_reg;
        end
    end

    assign first_pixel       = (idx_reg == '0);
    assign status.last_pixel = (idx_reg == LAST_IDX);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            temp_reg <= bad_pixel ? pixel.ambient_temp_c : pixel.pixel_temp_c;
            amb_reg  <= pixel.ambient_temp_c;
        end
        if (cmd.cap_old)
        begin
            old_reg <= $signed(rdata);
        end
        if (cmd.div_load)
        begin
            z_reg   <= z_next;
            est_reg <= div_prod[40:tfss_pkg::DIV5_SHIFT];
        end
        if (cmd.div_fix && (cmd.div_sel == tfss_pkg::DIV_PIXEL))
        begin
            f_reg <= div_res;
        end
        if (cmd.div_fix && (cmd.div_sel == tfss_pkg::DIV_AMB))
        begin
            ambf_reg <= div_res;
        end
        if (cmd.blend_mul)
        begin
            prod_reg <= 27'(blend_diff) * 27'($signed({1'b0, a_eff}));
        end
        if (cmd.blend_write)
        begin
            s_reg    <= s_next;
            done_reg <= status.last_pixel;
        end
        if (cmd.avg_sum)
        begin
            avg_y_reg <= 22'(pavg_reg) * 22'sd13 + 22'(pointer_reg) * 22'sd7
                         + tfss_pkg::AVG_OFFSET;
        end
        if (cmd.out_load)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            frame_seen_reg <= 1'b0;
            min_reg        <= 16'(tfss_pkg::TEMP_HI);
            max_reg        <= 16'(tfss_pkg::TEMP_LO);
            hot_col_reg    <= '0;
            hot_row_reg    <= '0;
            center_reg     <= '0;
            pointer_reg    <= '0;
            pavg_reg       <= '0;
            pavg_seen_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.blend_write)
            begin
                if (first_pixel || (s_next < min_reg))
                begin
                    min_reg <= s_next;
                end
                if (first_pixel || (s_next > max_reg))
                begin
                    max_reg     <= s_next;
                    hot_col_reg <= col_reg;
                    hot_row_reg <= row_reg;
                end
                if (status.last_pixel)
                begin
                    idx_reg        <= '0;
                    col_reg        <= '0;
                    row_reg        <= '0;
                    frame_seen_reg <= 1'b1;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (col_reg == LAST_COL)
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + 1'b1;
                    end
                    else
                    begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
            end
            if (cmd.cap_center)
            begin
                center_reg <= $signed(rdata);
            end
            if (cmd.cap_pointer)
            begin
                pointer_reg <= $signed(rdata);
            end
            if (cmd.div_fix && (cmd.div_sel == tfss_pkg::DIV_AVG))
            begin
                pavg_reg      <= pavg_seen_reg ? div_res : pointer_reg;
                pavg_seen_reg <= 1'b1;
            end
        end
    end

    assign result = result_reg;

endmodule

>>> rtl/core/thermal_frame_smoother_stats_unit.sv
// Each pixel's result is loaded into the output register in the sequencer's final step;
// the next pixel is taken only after that step, and the last pixel of a frame adds summary steps.
// The sequencer walks each pixel through the shared divide-by-five unit and the blend multiplier.
// Reset (rst_n, asynchronous, active low) clears the sequencer, the raster position and
// the frame statistics; alpha returns to 64/256 and the pointer to pixel (0,0).
// The frame store is not cleared; the first frame after reset overwrites every entry.
module thermal_frame_smoother_stats_unit #(
    parameter int FRAME_WIDTH  = 32,
    parameter int FRAME_HEIGHT = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pixel_valid,
    output logic                            pixel_ready,
    input  tfss_pkg::pixel_in_t             pixel,
    output logic                            result_valid,
    input  logic                            result_ready,
    output tfss_pkg::result_t               result,
    input  logic                            cfg_we,
    input  logic [tfss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tfss_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // The controller sequences one pixel at a time. A pixel transfer is taken only while
    // the controller is idle, but the result register at the output lets a new pixel
    // start while the previous result still waits for its transfer; the controller holds
    // in its final step only if that earlier result has not left yet.
    //
    // Per pixel the datapath converts Celsius to Fahrenheit with a reciprocal multiply
    // by one fifth plus a single correction, fetches the stored pixel from the frame
    // RAM, blends it with one multiply and writes it back while it updates the running
    // minimum, maximum and hotspot. On the last pixel of a frame the controller also
    // reads the center and pointer pixels back from the RAM, converts the ambient and
    // runs the pointer display average through the same divide unit.

    tfss_pkg::cmd_t    cmd;
    tfss_pkg::status_t status;

    tfss_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    tfss_datapath #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pixel     (pixel),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule

>>> rtl/core/tfss_checker.sv
module tfss_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              pixel_valid,
    input logic              pixel_ready,
    input logic              result_valid,
    input logic              result_ready,
    input tfss_pkg::result_t result
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

    // One pixel at a time: no second transfer right after a transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready |=> !pixel_ready)
    else $error("pixel taken while the previous one is in work");

    // Summary fields stay zero away from the end of a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.frame_done |->
            result.frame_min_f == 16'sd0 && result.frame_max_f == 16'sd0 &&
            result.hotspot_col == 5'd0 && result.hotspot_row == 5'd0 &&
            result.center_f == 16'sd0 && result.pointer_f == 16'sd0 &&
            result.pointer_display_f == 16'sd0 && result.ambient_f == 16'sd0)
    else $error("summary field set on a pixel that does not end a frame");

    // The last pixel lies between the frame minimum and maximum.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.frame_done |->
            result.frame_min_f <= result.smoothed_f &&
            result.smoothed_f <= result.frame_max_f)
    else $error("frame minimum or maximum inconsistent with the last pixel");

endmodule

bind thermal_frame_smoother_stats_unit tfss_checker u_checker (.*);
